>>> hdl/terminal_escape_key_decoder_top_defines.svh
// Assertion macros for the terminal escape key decoder checker.
// No dependencies; included by the checker file by its bare name.
`ifndef TERMINAL_ESCAPE_KEY_DECODER_TOP_DEFINES_SVH
`define TERMINAL_ESCAPE_KEY_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, gated off while reset is asserted
`define TEKD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, gated off while reset is asserted
`define TEKD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds across reset
`define TEKD_ASSERT_ALWAYS_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/tekd_pkg.sv
// Shared types and constants for the terminal escape key decoder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package tekd_pkg;

    // Parser mode
    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_ESC  = 2'd1,
        MODE_SEQ  = 2'd2
    } mode_t;

    // Key codes
    localparam logic [6:0] KEY_NONE      = 7'd0;
    localparam logic [6:0] KEY_ENTER     = 7'd1;
    localparam logic [6:0] KEY_TAB       = 7'd2;
    localparam logic [6:0] KEY_BACKSPACE = 7'd3;
    localparam logic [6:0] KEY_ESCAPE    = 7'd4;
    localparam logic [6:0] KEY_UP        = 7'd5;
    localparam logic [6:0] KEY_DOWN      = 7'd6;
    localparam logic [6:0] KEY_LEFT      = 7'd7;
    localparam logic [6:0] KEY_RIGHT     = 7'd8;
    localparam logic [6:0] KEY_HOME      = 7'd9;
    localparam logic [6:0] KEY_END       = 7'd10;
    localparam logic [6:0] KEY_PGUP      = 7'd11;
    localparam logic [6:0] KEY_PGDN      = 7'd12;

    // Byte values
    localparam logic [7:0] CH_ESC   = 8'h1b;
    localparam logic [7:0] CH_CSI   = 8'h5b;  // '['
    localparam logic [7:0] CH_SS3   = 8'h4f;  // 'O'
    localparam logic [7:0] CH_TILDE = 8'h7e;
    localparam logic [7:0] CH_FIVE  = 8'h35;
    localparam logic [7:0] CH_SIX   = 8'h36;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SEMI  = 8'h3b;
    localparam logic [7:0] CH_DEL   = 8'h7f;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_LAST  = 8'd126;
    localparam logic [7:0] CH_UP    = 8'h41;  // 'A'
    localparam logic [7:0] CH_DOWN  = 8'h42;  // 'B'
    localparam logic [7:0] CH_RIGHT = 8'h43;  // 'C'
    localparam logic [7:0] CH_LEFT  = 8'h44;  // 'D'
    localparam logic [7:0] CH_END   = 8'h46;  // 'F'
    localparam logic [7:0] CH_HOME  = 8'h48;  // 'H'

    localparam logic [7:0] COUNT_MAX = 8'd255;

    // One input byte with its batch marker
    typedef struct packed {
        logic [7:0] data_byte;
        logic       batch_end;
    } item_t;

    // Decoder result toward the output register
    typedef struct packed {
        logic       valid;
        logic [6:0] key_code;
    } result_t;

    // Map a byte seen outside any sequence
    function automatic logic [6:0] plain_key(input logic [7:0] b);
        logic [6:0] k;
        k = KEY_NONE;
        if (b == CH_CR || b == CH_LF) begin
            k = KEY_ENTER;
        end else if (b == CH_TAB) begin
            k = KEY_TAB;
        end else if (b == CH_DEL || b == CH_BS) begin
            k = KEY_BACKSPACE;
        end else if (b >= CH_SPACE && b <= CH_LAST) begin
            k = b[6:0];
        end
        return k;
    endfunction

    // Map the final byte of a cursor sequence
    function automatic logic [6:0] final_key(input logic [7:0] b);
        logic [6:0] k;
        unique case (b)
            CH_UP:    k = KEY_UP;
            CH_DOWN:  k = KEY_DOWN;
            CH_RIGHT: k = KEY_RIGHT;
            CH_LEFT:  k = KEY_LEFT;
            CH_HOME:  k = KEY_HOME;
            CH_END:   k = KEY_END;
            default:  k = KEY_NONE;
        endcase
        return k;
    endfunction

endpackage

>>> hdl/tekd_in_reg.sv
// Input register of the terminal escape key decoder.
// Depends on tekd_pkg for item_t.
`timescale 1ns / 1ps

module tekd_in_reg
    import tekd_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    input  item_t s_item,
    output logic  q_valid,
    input  logic  q_take,
    output item_t q_item
);

    logic  valid_reg;
    item_t item_reg;

    // Accept when empty or when the held request moves on this cycle
    assign s_ready = !valid_reg || q_take;
    assign q_valid = valid_reg;
    assign q_item  = item_reg;

    // Hold or advance the request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            item_reg <= s_item;
        end
    end

endmodule

>>> hdl/tekd_decoder.sv
// Escape sequence parser: mode, parameter count and first parameter state,
// plus the key mapping. Depends on tekd_pkg for types, codes and mappers.
`timescale 1ns / 1ps

module tekd_decoder
    import tekd_pkg::*;
#(
    parameter int PENDING_MAX = 16
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    fire,
    input  item_t   item,
    output result_t result
);

    localparam logic [8:0] PendLimit = 9'(PENDING_MAX);

    mode_t      mode_reg,  mode_next;
    logic [7:0] count_reg, count_next;
    logic [7:0] first_reg, first_next;
    logic [6:0] key;
    logic       is_param;

    assign is_param = (item.data_byte == CH_SEMI) ||
                      (item.data_byte >= CH_ZERO && item.data_byte <= CH_NINE);

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_IDLE;
            count_reg <= 8'd0;
            first_reg <= 8'd0;
        end else if (fire) begin
            mode_reg  <= mode_next;
            count_reg <= count_next;
            first_reg <= first_next;
        end
    end

    // Next state and key
    always_comb begin
        mode_next  = MODE_IDLE;
        count_next = count_reg;
        first_next = first_reg;
        key        = KEY_NONE;
        unique case (mode_reg)
            MODE_ESC: begin
                if (item.data_byte == CH_CSI || item.data_byte == CH_SS3) begin
                    mode_next  = MODE_SEQ;
                    count_next = 8'd0;
                    first_next = 8'd0;
                    if (item.batch_end && (9'd2 > PendLimit)) begin
                        mode_next = MODE_IDLE;
                    end
                end
            end
            MODE_SEQ: begin
                if (is_param) begin
                    mode_next = MODE_SEQ;
                    if (count_reg == 8'd0) begin
                        first_next = item.data_byte;
                    end
                    if (count_reg != COUNT_MAX) begin
                        count_next = count_reg + 8'd1;
                    end
                    // Drop an overlong pending sequence at batch end
                    if (item.batch_end && ((9'd2 + {1'b0, count_next}) > PendLimit)) begin
                        mode_next = MODE_IDLE;
                    end
                end else if (item.data_byte == CH_TILDE) begin
                    if (count_reg == 8'd1 && first_reg == CH_FIVE) begin
                        key = KEY_PGUP;
                    end else if (count_reg == 8'd1 && first_reg == CH_SIX) begin
                        key = KEY_PGDN;
                    end
                end else begin
                    key = final_key(item.data_byte);
                end
            end
            default: begin
                if (item.data_byte == CH_ESC) begin
                    if (item.batch_end) begin
                        key = KEY_ESCAPE;
                    end else begin
                        mode_next = MODE_ESC;
                    end
                end else begin
                    key = plain_key(item.data_byte);
                end
            end
        endcase
    end

    assign result.valid    = fire && (key != KEY_NONE);
    assign result.key_code = key;

endmodule

>>> hdl/tekd_out_reg.sv
// Result register of the terminal escape key decoder.
// Depends on tekd_pkg for result_t.
`timescale 1ns / 1ps

module tekd_out_reg
    import tekd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  result_t    result,
    output logic       can_take,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [6:0] m_key
);

    logic       valid_reg;
    logic [6:0] key_reg;

    // Load when empty or when the held result is taken
    assign can_take = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_key    = key_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (can_take) begin
            valid_reg <= result.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (can_take && result.valid) begin
            key_reg <= result.key_code;
        end
    end

endmodule

>>> hdl/terminal_escape_key_decoder_top.sv
// Channel   Dir  tdata                   tlast
// s_axis    in   [7:0] data_byte         batch_end
// m_axis    out  [6:0] key_code, [7] 0   -
//
// One byte per cycle unless the output stalls, with no bubbles.
// Bytes that end in no key (control bytes, sequence bytes) give no result.
// A byte is held in the input register, its key in the output register.
// Reset is synchronous, active low, and clears the parser to idle.
// A stalled result holds in the output register while one more byte waits.
// Depends on tekd_pkg, tekd_in_reg, tekd_decoder and tekd_out_reg.
`timescale 1ns / 1ps

module terminal_escape_key_decoder_top
    import tekd_pkg::*;
#(
    parameter int PENDING_MAX = 16
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,   // batch_end
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [6:0] key_code, [7] zero
    output logic       m_tlast
);

    item_t      s_item;
    item_t      q_item;
    logic       q_valid;
    logic       can_take;
    logic       fire;
    result_t    result;
    logic [6:0] m_key;

    assign s_item.data_byte = s_tdata;
    assign s_item.batch_end = s_tlast;

    // Advance the held byte into the parser when the result slot is free
    assign fire = q_valid && can_take;

    tekd_in_reg u_in_reg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .s_item  (s_item),
        .q_valid (q_valid),
        .q_take  (can_take),
        .q_item  (q_item)
    );

    tekd_decoder #(
        .PENDING_MAX (PENDING_MAX)
    ) u_decoder (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (q_item),
        .result  (result)
    );

    tekd_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .result   (result),
        .can_take (can_take),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_key    (m_key)
    );

    assign m_tdata = {1'b0, m_key};
    assign m_tlast = 1'b0;

endmodule

>>> hdl/tekd_checker.sv
// Port-level checks for the terminal escape key decoder, bound to the top.
// Depends on tekd_pkg and terminal_escape_key_decoder_top_defines.svh for the macros.
`timescale 1ns / 1ps
`include "terminal_escape_key_decoder_top_defines.svh"

module tekd_checker
    import tekd_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    logic key_ok;
    logic stalled;

    // Defined codes: named keys or printable characters, top bit and tlast low
    assign key_ok = (m_tdata[7] == 1'b0) && (m_tdata[6:0] != KEY_NONE) &&
                    ((m_tdata[6:0] <= KEY_PGDN) ||
                     ((m_tdata >= CH_SPACE) && (m_tdata <= CH_LAST))) &&
                    (m_tlast == 1'b0);
    assign stalled = m_tvalid && !m_tready;

    // Reset empties the result register
    `TEKD_ASSERT_ALWAYS_NEXT(a_reset_clears, !aresetn, !m_tvalid, "result valid after reset")

    // An empty result slot always lets a request in
    `TEKD_ASSERT_NOW(a_ready_when_empty, !m_tvalid, s_tready, "input stalled with empty output")

    // Only defined key codes leave the block
    `TEKD_ASSERT_NOW(a_key_range, m_tvalid, key_ok, "undefined key code")

    // A stalled result holds
    `TEKD_ASSERT_NEXT(a_hold, stalled, m_tvalid && $stable(m_tdata), "stalled result changed")

endmodule

bind terminal_escape_key_decoder_top tekd_checker u_tekd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
